### hw/rtl/ritoa_pkg.sv
// ritoa_pkg: shared widths, character constants and lookup functions for the
// radix integer-to-ascii converter. No dependencies; imported by all modules.
`timescale 1ns / 1ps

package ritoa_pkg;

    localparam int VALUE_W     = 64;
    localparam int BASE_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;
    localparam int ERR_LEN     = 7;
    localparam int ERR_IDX_W   = 3;

    localparam logic [CHAR_W-1:0]    CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]    CHAR_UPPER = 8'h41;
    localparam logic [BASE_W-1:0]    DEC_DIGITS = 6'd10;
    localparam logic [BASE_W-1:0]    MIN_RADIX  = 6'd2;
    localparam logic [ERR_IDX_W-1:0] ERR_LAST   = 3'd6;

    // ascii code of one digit value
    function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {{(CHAR_W-BASE_W){1'b0}}, d};
        if (d < DEC_DIGITS) begin
            return CHAR_ZERO + dw;
        end
        return CHAR_UPPER + dw - {{(CHAR_W-BASE_W){1'b0}}, DEC_DIGITS};
    endfunction

    // characters of the "(error)" text
    function automatic logic [CHAR_W-1:0] err_char(input logic [ERR_IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h28;  // (
            3'd1:    c = 8'h65;  // e
            3'd2:    c = 8'h72;  // r
            3'd3:    c = 8'h72;  // r
            3'd4:    c = 8'h6F;  // o
            3'd5:    c = 8'h72;  // r
            default: c = 8'h29;  // )
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/ritoa_div.sv
// ritoa_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on ritoa_pkg for the divisor width.
`timescale 1ns / 1ps

module ritoa_div
    import ritoa_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WIDTH-1:0]  i_dividend,
    input  logic [BASE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [WIDTH-1:0]  o_quotient,
    output logic [BASE_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WIDTH-1:0]  r_quo;
    logic [BASE_W-1:0] r_rem;
    logic [BASE_W-1:0] r_div;

    logic [BASE_W:0]   rem_t;
    logic [BASE_W:0]   rem_diff;
    logic              ge;
    logic [BASE_W-1:0] n_rem;

    // dividend bits shift out of the top while quotient bits shift in below
    always_comb begin
        rem_t    = {r_rem, r_quo[WIDTH-1]};
        ge       = rem_t >= {1'b0, r_div};
        rem_diff = rem_t - {1'b0, r_div};
        n_rem    = ge ? rem_diff[BASE_W-1:0] : rem_t[BASE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_LAST;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[WIDTH-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### hw/rtl/radix_integer_to_ascii_unit.sv
// radix_integer_to_ascii_unit: top level, converts a value to ascii digits.
// Depends on ritoa_pkg and ritoa_div.
`timescale 1ns / 1ps

// Converts one unsigned value per input beat into its digits in the given base,
// most significant first, one ascii character per output beat, with tlast on
// the final character. Only the low VALUE_BITS bits of the value are used.
// Digits come from repeated division by the base in a bit-serial divider;
// digits are stored in a small memory and then read back in reverse, each
// character passing through a read state and then an output state. A base
// outside 2 to MAX_RADIX yields the seven characters "(error)" with tuser set,
// one per cycle while the output is not held back. One item is processed at a
// time; the input is ready whenever the unit is idle, even while the last
// character still waits in the output register.

module radix_integer_to_ascii_unit
    import ritoa_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_RADIX  = 36
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [63:0] value, [69:64] base, zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] character
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser   // [0] base_error
);

    localparam int AW = $clog2(VALUE_BITS);
    localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(MAX_RADIX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_OUT,
        S_ERR
    } t_state;

    t_state                r_state;
    logic [BASE_W-1:0]     r_base;
    logic [AW-1:0]         r_wptr;
    logic [AW-1:0]         r_rptr;
    logic [ERR_IDX_W-1:0]  r_eidx;
    logic [BASE_W-1:0]     r_rdata;
    logic [BASE_W-1:0]     r_mem [VALUE_BITS];
    logic                  r_ovalid;
    logic [CHAR_W-1:0]     r_ochar;
    logic                  r_olast;
    logic                  r_oerr;

    logic                  in_acc;
    logic [BASE_W-1:0]     in_base;
    logic [VALUE_BITS-1:0] in_value;
    logic                  base_ok;
    logic                  out_free;
    logic                  out_emit;
    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [BASE_W-1:0]     div_divisor;
    logic [VALUE_BITS-1:0] div_quo;
    logic [BASE_W-1:0]     div_rem;
    logic                  quo_zero;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_value      = s_axis_tdata[VALUE_BITS-1:0];
    assign in_base       = s_axis_tdata[VALUE_W +: BASE_W];
    assign base_ok       = (in_base >= MIN_RADIX) && (in_base <= MAX_BASE);
    assign out_free      = !r_ovalid || m_axis_tready;
    assign out_emit      = ((r_state == S_OUT) || (r_state == S_ERR)) && out_free;
    assign quo_zero      = (div_quo == '0);

    assign div_start    = (in_acc && base_ok) ||
                          ((r_state == S_DIV) && div_done && !quo_zero);
    assign div_dividend = (r_state == S_IDLE) ? in_value : div_quo;
    assign div_divisor  = (r_state == S_IDLE) ? in_base : r_base;

    ritoa_div #(
        .WIDTH (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // digit store, least significant digit at address zero
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && div_done) begin
            r_mem[r_wptr] <= div_rem;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_eidx   <= '0;
        end else begin
            if (out_emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_base <= in_base;
                        r_wptr <= '0;
                        r_eidx <= '0;
                        r_state <= base_ok ? S_DIV : S_ERR;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_wptr <= r_wptr + 1'b1;
                        if (quo_zero) begin
                            r_rptr  <= r_wptr;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ochar  <= digit_char(r_rdata);
                        r_olast  <= (r_rptr == '0);
                        r_oerr   <= 1'b0;
                        if (r_rptr == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rptr  <= r_rptr - 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_ochar  <= err_char(r_eidx);
                        r_olast  <= (r_eidx == ERR_LAST);
                        r_oerr   <= 1'b1;
                        r_eidx   <= r_eidx + 1'b1;
                        if (r_eidx == ERR_LAST) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_ochar;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oerr;

    // divider remainder always a legal digit of the current base
    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && div_done |-> div_rem < r_base)
        else $error("remainder not below base");

    // digit beats carry only 0-9 or A-Z
    a_digit_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_oerr |->
            ((r_ochar >= 8'h30) && (r_ochar <= 8'h39)) ||
            ((r_ochar >= 8'h41) && (r_ochar <= 8'h5A)))
        else $error("digit beat outside 0-9 A-Z");

    // the error text ends on the closing parenthesis
    a_err_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_oerr && r_olast |-> r_ochar == 8'h29)
        else $error("error text does not end with )");

    // divider never restarts while the unit is emitting characters
    a_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) || (r_state == S_OUT) || (r_state == S_ERR) |-> !div_start)
        else $error("divider started outside division");

endmodule

### tb/ritoa_stream_checker.sv
// ritoa_stream_checker: watches both streams of the integer-to-ascii unit, predicts the
// characters of every accepted beat and compares them with the output beats.
// Depends on ritoa_pkg for widths and character constants.
`timescale 1ns / 1ps

module ritoa_stream_checker
    import ritoa_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_RADIX  = 36
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_TDATA_W-1:0]  i_in_data,   // [63:0] value, [69:64] base, zero pad
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,  // [7:0] character
    input  logic                   i_out_last,
    input  logic                   i_out_user,  // [0] base_error
    output int                     o_mismatches,
    output int                     o_pending,
    output int                     o_chars,
    output int                     o_conversions
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              err;
    } t_char_beat;

    localparam logic [VALUE_W-1:0]      VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);
    // first character sits in the top byte
    localparam logic [8*ERR_LEN-1:0]    ERR_TEXT   = "(error)";

    t_char_beat char_q[$];
    t_char_beat exp_beat;
    int         mismatch_cnt = 0;
    int         pending_cnt  = 0;
    int         char_cnt     = 0;
    int         conv_cnt     = 0;

    assign o_mismatches  = mismatch_cnt;
    assign o_pending     = pending_cnt;
    assign o_chars       = char_cnt;
    assign o_conversions = conv_cnt;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s, got %0h, want %0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // queue the characters one conversion must produce
    task automatic predict_chars(input logic [VALUE_W-1:0] raw, input logic [BASE_W-1:0] base);
        logic [VALUE_W-1:0] num;
        logic [VALUE_W-1:0] radix;
        logic [VALUE_W-1:0] rem;
        logic [CHAR_W-1:0]  dig;
        logic [CHAR_W-1:0]  rev_digits [VALUE_W];
        t_char_beat         beat;
        int                 n;
        int                 k;
        num = raw & VALUE_MASK;
        n   = 0;
        if (base < MIN_RADIX || base > MAX_RADIX) begin
            for (k = 0; k < ERR_LEN; k++) begin
                beat.ch   = ERR_TEXT[8*(ERR_LEN-1-k) +: 8];
                beat.last = (k == ERR_LEN - 1);
                beat.err  = 1'b1;
                char_q.push_back(beat);
            end
        end else begin
            radix = {{(VALUE_W-BASE_W){1'b0}}, base};
            // least significant digit comes out first, so collect then reverse
            do begin
                rem = num % radix;
                dig = rem[CHAR_W-1:0];
                if (rem < DEC_DIGITS) begin
                    rev_digits[n] = CHAR_ZERO + dig;
                end else begin
                    rev_digits[n] = CHAR_UPPER + dig - DEC_DIGITS;
                end
                n++;
                num = num / radix;
            end while (num != 0);
            for (k = n - 1; k >= 0; k--) begin
                beat.ch   = rev_digits[k];
                beat.last = (k == 0);
                beat.err  = 1'b0;
                char_q.push_back(beat);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_q.delete();
        end else begin
            // pop before push: a beat never answers an item taken on the same edge
            if (i_out_valid && i_out_ready) begin
                char_cnt++;
                if (char_q.size() == 0) begin
                    report_mismatch("character beat with nothing expected",
                                    {24'd0, i_out_data}, 32'd0);
                end else begin
                    exp_beat = char_q.pop_front();
                    if (i_out_data !== exp_beat.ch) begin
                        report_mismatch("character", {24'd0, i_out_data}, {24'd0, exp_beat.ch});
                    end
                    if (i_out_last !== exp_beat.last) begin
                        report_mismatch("tlast", {31'd0, i_out_last}, {31'd0, exp_beat.last});
                    end
                    if (i_out_user !== exp_beat.err) begin
                        report_mismatch("base error flag", {31'd0, i_out_user},
                                        {31'd0, exp_beat.err});
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_chars(i_in_data[VALUE_W-1:0], i_in_data[VALUE_W +: BASE_W]);
                conv_cnt++;
            end
        end
        pending_cnt = char_q.size();
    end

endmodule

### tb/tb_radix_integer_to_ascii_unit.sv
// tb_radix_integer_to_ascii_unit: drives value/base beats into the converter, pulls the
// character stream with random back-pressure and gives the verdict.
// Depends on ritoa_pkg, radix_integer_to_ascii_unit and ritoa_stream_checker.
`timescale 1ns / 1ps

module tb_radix_integer_to_ascii_unit;
    import ritoa_pkg::*;

    localparam int VALUE_BITS   = 64;
    localparam int MAX_RADIX    = 36;
    localparam int N_RANDOM     = 300;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int BASE_TOP     = (1 << BASE_W) - 1;
    localparam int PAD_W        = IN_TDATA_W - VALUE_W - BASE_W;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [63:0] value, [69:64] base, zero pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] character
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;         // [0] base_error

    int mismatches;
    int pending;
    int chars_seen;
    int conversions;

    int tx_idle_pct = 30;
    int rx_idle_pct = 45;
    bit hold_go     = 1'b0;
    bit hold_done   = 1'b0;
    int n_directed  = 0;

    always #5 i_clk = ~i_clk;

    radix_integer_to_ascii_unit #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_RADIX  (MAX_RADIX)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    ritoa_stream_checker #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_RADIX  (MAX_RADIX)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_last    (m_axis_tlast),
        .i_out_user    (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_chars       (chars_seen),
        .o_conversions (conversions)
    );

    // offer one beat, hold it until taken, then maybe leave a gap
    task automatic send_conversion(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, base, value};
        do @(posedge i_clk); while (!s_axis_tready);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    // values of random bit length, with zero, all ones and single set bits mixed in
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 nbits;
        v = {$urandom, $urandom};
        case ($urandom_range(11))
            0:       v = '0;
            1:       v = '1;
            2:       v = {{(VALUE_W-1){1'b0}}, 1'b1} << $urandom_range(VALUE_W - 1);
            default: begin
                nbits = $urandom_range(VALUE_W, 1);
                v     = v & ({VALUE_W{1'b1}} >> (VALUE_W - nbits));
            end
        endcase
        return v;
    endfunction

    function automatic logic [BASE_W-1:0] random_base();
        logic [31:0] r;
        case ($urandom_range(9))
            0:       r = $urandom_range(1) ? MIN_RADIX : MAX_RADIX;
            1, 2:    r = $urandom_range(1) ? $urandom_range(1)
                                           : $urandom_range(BASE_TOP, MAX_RADIX + 1);
            default: r = $urandom_range(MAX_RADIX, MIN_RADIX);
        endcase
        return r[BASE_W-1:0];
    endfunction

    task automatic send_directed(input logic [VALUE_W-1:0] value, input int base);
        logic [31:0] b;
        b = base;
        send_conversion(value, b[BASE_W-1:0]);
        n_directed++;
    endtask

    initial begin : stimulus
        int k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_directed('0, 10);
        send_directed('0, MAX_RADIX);
        send_directed(64'd1, 2);
        send_directed(64'd9, 10);
        send_directed(64'd10, 11);
        send_directed(64'd35, MAX_RADIX);
        send_directed(64'd36, MAX_RADIX);
        send_directed(64'd255, 16);
        send_directed(64'd12345, 10);
        send_directed(64'h8000_0000_0000_0000, 2);
        send_directed('1, 2);
        send_directed('1, 10);
        send_directed('1, 16);
        send_directed('1, MAX_RADIX);
        send_directed(64'h0123_4567_89AB_CDEF, 16);
        // invalid radix on both sides of the legal range
        send_directed(64'd77, 0);
        send_directed(64'd77, 1);
        send_directed('1, MAX_RADIX + 1);
        send_directed('0, BASE_TOP);
        send_directed(64'h5555_5555_5555_5555, 42);

        for (k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 3) begin
                tx_idle_pct = 45;
                rx_idle_pct = 30;
            end
            if (k == 2 * N_RANDOM / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_go     = 1'b1;
            end
            send_conversion(random_value(), random_base());
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d conversions (%0d directed), checked %0d characters",
                 conversions, n_directed, chars_seen);
        $display("covered bases 0..%0d incl. invalid ones, values up to %0d bits, "
                 , BASE_TOP, VALUE_BITS, "three idle mixes and one long output hold");
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                // long hold-off while the sender keeps offering beats
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
